// ----- design/jtmc_pkg.sv -----
// ----------------------------------------------------------------------------
// jtmc_pkg
// Shared types, constants and mapping functions for the stick-to-motor block.
// ----------------------------------------------------------------------------
package jtmc_pkg;

	localparam logic [7:0] VALID_ID       = 8'h73;
	localparam logic [7:0] CENTER         = 8'd128;
	localparam logic [7:0] SAT_STEP       = 8'd62;
	localparam logic [7:0] SAT_SPAN       = 8'd63;
	localparam logic [7:0] STOP_ONE       = 8'd64;
	localparam logic [7:0] STOP_TWO       = 8'd192;
	localparam logic [7:0] COUNT_MAX      = 8'd255;

	localparam logic [7:0] DIV_RST        = 8'd3;
	localparam logic [7:0] DEAD_LOW_RST   = 8'd90;
	localparam logic [7:0] DEAD_HIGH_RST  = 8'd166;
	localparam logic [7:0] FAIL_LIMIT_RST = 8'd50;

	localparam int DIV_STEPS = 8;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [7:0] {
		REG_DIVIDE     = 8'd0,
		REG_DEAD_LOW   = 8'd1,
		REG_DEAD_HIGH  = 8'd2,
		REG_FAIL_LIMIT = 8'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		CLS_STOP = 2'd0,
		CLS_FWD  = 2'd1,
		CLS_REV  = 2'd2
	} stick_cls_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DIVL  = 5'b00010,
		S_LOADR = 5'b00100,
		S_DIVR  = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	typedef struct packed {
		logic capture;
		logic div_step;
		logic load_right;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic bad_id;
		logic trip;
		logic div_last;
		logic out_free;
	} status_t;

	function automatic stick_cls_t classify(input logic [7:0] x, input logic [7:0] lo,
		input logic [7:0] hi);
		stick_cls_t c;
		if (x >= lo && x <= hi) begin
			c = CLS_STOP;
		end else if (x > hi) begin
			c = CLS_FWD;
		end else begin
			c = CLS_REV;
		end
		return c;
	endfunction

	function automatic logic [7:0] stick_offset(input logic [7:0] x, input stick_cls_t c);
		logic [7:0] off;
		off = 8'd0;
		case (c)
			CLS_FWD: begin
				if (x >= CENTER) off = x - CENTER;
			end
			CLS_REV: begin
				if (x <= CENTER) off = CENTER - x;
			end
			default: off = 8'd0;
		endcase
		return off;
	endfunction

	function automatic logic [7:0] map_cmd(input stick_cls_t c, input logic [7:0] q,
		input logic [7:0] stop);
		logic [7:0] r;
		case (c)
			CLS_FWD: r = (q >= SAT_STEP) ? stop - SAT_SPAN : stop - q;
			CLS_REV: r = (q >= SAT_STEP) ? stop + SAT_SPAN : stop + q;
			default: r = stop;
		endcase
		return r;
	endfunction

endpackage

// ----- design/jtmc_ctrl.sv -----
// ----------------------------------------------------------------------------
// jtmc_ctrl
// Sequencer: accepts a poll, runs the shared divider per stick on a valid reply, emits.
// ----------------------------------------------------------------------------
module jtmc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              poll_valid,
	output logic              poll_stall,
	input  jtmc_pkg::status_t status,
	output jtmc_pkg::cmd_t    cmd
);

	jtmc_pkg::state_t state_q;
	jtmc_pkg::state_t state_nxt;

	assign poll_stall = (state_q != jtmc_pkg::S_IDLE);

	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		case (state_q)
			jtmc_pkg::S_IDLE: begin
				if (poll_valid) begin
					cmd.capture = 1'b1;
					if (!status.bad_id) begin
						state_nxt = jtmc_pkg::S_DIVL;
					end else if (status.trip) begin
						state_nxt = jtmc_pkg::S_EMIT;
					end
				end
			end
			jtmc_pkg::S_DIVL: begin
				cmd.div_step = 1'b1;
				if (status.div_last) state_nxt = jtmc_pkg::S_LOADR;
			end
			jtmc_pkg::S_LOADR: begin
				cmd.load_right = 1'b1;
				state_nxt      = jtmc_pkg::S_DIVR;
			end
			jtmc_pkg::S_DIVR: begin
				cmd.div_step = 1'b1;
				if (status.div_last) state_nxt = jtmc_pkg::S_EMIT;
			end
			jtmc_pkg::S_EMIT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = jtmc_pkg::S_IDLE;
				end
			end
			default: state_nxt = jtmc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jtmc_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- design/jtmc_dp.sv -----
// ----------------------------------------------------------------------------
// jtmc_dp
// Datapath: config registers, failure count, serial divider, output register.
// ----------------------------------------------------------------------------
module jtmc_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  jtmc_pkg::cmd_t    cmd,
	output jtmc_pkg::status_t status,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic [7:0]        reply_id,
	input  logic [7:0]        right_stick_y,
	input  logic [7:0]        left_stick_y,
	output logic              motor_valid,
	input  logic              motor_stall,
	output logic [6:0]        left_motor_command,
	output logic [7:0]        right_motor_command,
	output logic              reinit_request
);

	logic [7:0] divide_factor_q;
	logic [7:0] dead_low_q;
	logic [7:0] dead_high_q;
	logic [7:0] fail_limit_q;
	logic [7:0] fail_count_q;

	jtmc_pkg::stick_cls_t cls_l_q;
	jtmc_pkg::stick_cls_t cls_r_q;
	logic [7:0]           stick_r_q;
	logic                 stop_q;
	logic [6:0]           left_cmd_q;

	logic [7:0]                    rem_q;
	logic [7:0]                    quo_q;
	logic [jtmc_pkg::DIV_CNT_W-1:0] cnt_q;

	logic       motor_valid_q;
	logic [6:0] left_out_q;
	logic [7:0] right_out_q;
	logic       reinit_q;

	logic                 bad_id;
	logic [7:0]           count_inc;
	logic [7:0]           div_eff;
	logic [8:0]           shifted;
	logic [8:0]           diff;
	jtmc_pkg::stick_cls_t cls_l_in;
	jtmc_pkg::stick_cls_t cls_r_in;
	logic [7:0]           left_map;
	logic [7:0]           right_map;

	assign bad_id    = (reply_id != jtmc_pkg::VALID_ID);
	assign count_inc = (fail_count_q == jtmc_pkg::COUNT_MAX) ? jtmc_pkg::COUNT_MAX
		: fail_count_q + 8'd1;
	assign div_eff   = (divide_factor_q == 8'd0) ? 8'd1 : divide_factor_q;
	assign shifted   = {rem_q, quo_q[7]};
	assign diff      = shifted - {1'b0, div_eff};
	assign cls_l_in  = jtmc_pkg::classify(left_stick_y, dead_low_q, dead_high_q);
	assign cls_r_in  = jtmc_pkg::classify(right_stick_y, dead_low_q, dead_high_q);
	assign left_map  = jtmc_pkg::map_cmd(cls_l_q, quo_q, jtmc_pkg::STOP_ONE);
	assign right_map = jtmc_pkg::map_cmd(cls_r_q, quo_q, jtmc_pkg::STOP_TWO);

	assign status.bad_id   = bad_id;
	assign status.trip     = bad_id && (count_inc > fail_limit_q);
	assign status.div_last = (cnt_q == jtmc_pkg::DIV_CNT_W'(jtmc_pkg::DIV_STEPS - 1));
	assign status.out_free = !motor_valid_q || !motor_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divide_factor_q <= jtmc_pkg::DIV_RST;
			dead_low_q      <= jtmc_pkg::DEAD_LOW_RST;
			dead_high_q     <= jtmc_pkg::DEAD_HIGH_RST;
			fail_limit_q    <= jtmc_pkg::FAIL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				jtmc_pkg::REG_DIVIDE:     divide_factor_q <= cfg_data;
				jtmc_pkg::REG_DEAD_LOW:   dead_low_q      <= cfg_data;
				jtmc_pkg::REG_DEAD_HIGH:  dead_high_q     <= cfg_data;
				jtmc_pkg::REG_FAIL_LIMIT: fail_limit_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count_q <= 8'd0;
			stop_q       <= 1'b0;
			cnt_q        <= '0;
		end else if (cmd.capture) begin
			fail_count_q <= bad_id ? count_inc : 8'd0;
			stop_q       <= bad_id;
			cnt_q        <= '0;
		end else if (cmd.load_right) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cls_l_q   <= cls_l_in;
			cls_r_q   <= cls_r_in;
			stick_r_q <= right_stick_y;
			rem_q     <= 8'd0;
			quo_q     <= jtmc_pkg::stick_offset(left_stick_y, cls_l_in);
		end else if (cmd.load_right) begin
			left_cmd_q <= left_map[6:0];
			rem_q      <= 8'd0;
			quo_q      <= jtmc_pkg::stick_offset(stick_r_q, cls_r_q);
		end else if (cmd.div_step) begin
			if (!diff[8]) begin
				rem_q <= diff[7:0];
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				rem_q <= shifted[7:0];
				quo_q <= {quo_q[6:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			motor_valid_q <= 1'b1;
		end else if (!motor_stall) begin
			motor_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (stop_q) begin
				left_out_q  <= jtmc_pkg::STOP_ONE[6:0];
				right_out_q <= jtmc_pkg::STOP_TWO;
				reinit_q    <= 1'b1;
			end else begin
				left_out_q  <= left_cmd_q;
				right_out_q <= right_map;
				reinit_q    <= 1'b0;
			end
		end
	end

	assign motor_valid         = motor_valid_q;
	assign left_motor_command  = left_out_q;
	assign right_motor_command = right_out_q;
	assign reinit_request      = reinit_q;

endmodule

// ----- design/joystick_to_motor_command.sv -----
// ----------------------------------------------------------------------------
// joystick_to_motor_command
// Maps a gamepad poll to two motor command bytes, with a failure watchdog.
// ----------------------------------------------------------------------------
// Channel   Handshake               Payload
// poll      poll_valid/poll_stall   reply_id, right_stick_y, left_stick_y
// motor     motor_valid/motor_stall left/right_motor_command, reinit_request
// cfg       cfg_valid/cfg_ready     cfg_index, cfg_data
//
// A valid poll runs capture, the left-stick divide, the right-stick reload and
// divide, and output load, in that order, on one shared restoring divider.
// A failed poll ends at capture, or goes on to output load for the stop request.
// The output register frees the poll side while a request waits on motor_stall.
// Reset is asynchronous; cfg_ready is always high.
// ----------------------------------------------------------------------------
module joystick_to_motor_command (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       poll_valid,
	output logic       poll_stall,
	input  logic [7:0] reply_id,
	input  logic [7:0] right_stick_y,
	input  logic [7:0] left_stick_y,
	output logic       motor_valid,
	input  logic       motor_stall,
	output logic [6:0] left_motor_command,
	output logic [7:0] right_motor_command,
	output logic       reinit_request,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data
);

	jtmc_pkg::cmd_t    cmd;
	jtmc_pkg::status_t status;

	assign cfg_ready = 1'b1;

	jtmc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.poll_valid (poll_valid),
		.poll_stall (poll_stall),
		.status     (status),
		.cmd        (cmd)
	);

	jtmc_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.cfg_we              (cfg_valid && cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.reply_id            (reply_id),
		.right_stick_y       (right_stick_y),
		.left_stick_y        (left_stick_y),
		.motor_valid         (motor_valid),
		.motor_stall         (motor_stall),
		.left_motor_command  (left_motor_command),
		.right_motor_command (right_motor_command),
		.reinit_request      (reinit_request)
	);

`ifndef SYNTHESIS
	a_valid_poll_busy: assert property (@(posedge clk) disable iff (!arst_n)
		poll_valid && !poll_stall && reply_id == jtmc_pkg::VALID_ID |=> poll_stall)
		else $error("valid poll did not start the divider sequence");

	a_reinit_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		motor_valid && reinit_request |->
			left_motor_command == jtmc_pkg::STOP_ONE[6:0] &&
			right_motor_command == jtmc_pkg::STOP_TWO)
		else $error("reinit request without stop commands");

	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		motor_valid |-> left_motor_command != 7'd0 && right_motor_command[7] &&
			right_motor_command != 8'd128)
		else $error("motor command out of range");
`endif

endmodule
